### hdl/stc_pkg.sv
// Package for the signal trend classifier.
// Holds behaviour codes, register indexes, reset values and operand widths.
// No dependencies.
package stc_pkg;

    localparam int unsigned DividendWidth = 65;
    localparam int unsigned MulWidth      = 33;
    localparam int unsigned CfgIndexWidth = 4;

    typedef enum logic [2:0] {
        BEH_UNKNOWN      = 3'd0,
        BEH_STABLE       = 3'd1,
        BEH_INCREASING   = 3'd2,
        BEH_DECREASING   = 3'd3,
        BEH_FLUCTUATING  = 3'd4,
        BEH_INTERMITTENT = 3'd5
    } behavior_t;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_STABLE_STEP = 4'd0,
        REG_TREND       = 4'd1,
        REG_FLUCTUATION = 4'd2,
        REG_HOLD_MS     = 4'd3
    } reg_index_t;

    localparam logic OP_SAMPLE = 1'b0;

    localparam logic [31:0] StableStepReset  = 32'd3277;
    localparam logic [31:0] TrendReset       = 32'd6554;
    localparam logic [31:0] FluctuationReset = 32'd32768;
    localparam logic [31:0] HoldMsReset      = 32'd10000;

    // start/finish pair between the sequencer and a serial unit
    typedef struct packed {
        logic start;
    } unit_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

### hdl/stc_if.sv
// Channel interfaces of the signal trend classifier.
// No dependencies.
interface stc_item_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] sample_value;
    logic [31:0] now_ms;

    modport source (output valid, op, sample_value, now_ms, input ready);
    modport sink   (input valid, op, sample_value, now_ms, output ready);
endinterface

interface stc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  behavior;
    logic [31:0] mean_out;
    logic [63:0] variance_out;
    logic [31:0] std_dev_out;
    logic [31:0] trend_out;
    logic [31:0] latest_value;
    logic [31:0] samples_seen;
    logic        is_settled;

    modport source (output valid, behavior, mean_out, variance_out, std_dev_out,
                    trend_out, latest_value, samples_seen, is_settled, input ready);
    modport sink   (input valid, behavior, mean_out, variance_out, std_dev_out,
                    trend_out, latest_value, samples_seen, is_settled, output ready);
endinterface

### hdl/signal_trend_classifier_core.sv
// Signal trend classifier top level: sequencer, statistics state and result register.
// Depends on stc_pkg, stc_if, stc_divu, stc_mulu and stc_isqrt.
// Processing: a new sample runs the mean division, the squaring, the variance division and
// the root in turn, each unit started and handed over by the sequencer, then loads the output
// register; a re-evaluation and the first sample go straight to the output register.
// One item at a time: the next item is taken once the result register is loaded; a result
// left waiting stalls the next.
// Reset clears all statistics and restores the register reset values.
module signal_trend_classifier_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [stc_pkg::CfgIndexWidth-1:0]     cfg_index,
    input  logic [31:0]                           cfg_data,
    stc_item_if.sink                              item,
    stc_result_if.source                          result
);
    typedef enum logic [2:0] {
        S_IDLE, S_DIV_MEAN, S_MUL, S_DIV_VAR, S_SQRT, S_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [31:0] stable_step_limit_reg, trend_limit_reg;
    logic [31:0] fluctuation_limit_reg, stable_hold_ms_reg;

    // statistics
    logic signed [31:0] last_sample_reg, mean_reg, last_step_reg;
    logic [63:0] variance_reg;
    logic [31:0] deviation_reg, total_reg, run_reg, run_start_reg, now_reg;
    logic        settled_reg;
    logic [2:0]  class_reg;
    logic        neg_reg, var_add_reg;

    // marks an item that only seeded the state or found no samples at all
    logic        seed_item_reg;

    // serial units
    stc_pkg::unit_ctrl_t div_ctrl_reg, mul_ctrl_reg, sqrt_ctrl_reg;
    stc_pkg::unit_stat_t div_stat, mul_stat, sqrt_stat;
    logic [stc_pkg::DividendWidth-1:0] div_a_reg, div_q;
    logic [stc_pkg::MulWidth-1:0]      mul_a_reg;
    logic [63:0]                       product;
    logic [31:0]                       root;

    // output register
    logic        out_valid_reg;
    logic [2:0]  o_beh_reg;
    logic [31:0] o_mean_reg, o_dev_reg, o_trend_reg, o_latest_reg, o_seen_reg;
    logic [63:0] o_var_reg;
    logic        o_settled_reg;

    stc_divu u_div (.clk, .rst_n, .ctrl(div_ctrl_reg), .dividend(div_a_reg),
                    .divisor(total_reg), .stat(div_stat), .quotient(div_q));
    stc_mulu u_mul (.clk, .rst_n, .ctrl(mul_ctrl_reg), .a(mul_a_reg), .b(mul_a_reg),
                    .stat(mul_stat), .product(product));
    stc_isqrt u_sqrt (.clk, .rst_n, .ctrl(sqrt_ctrl_reg), .radicand(variance_reg),
                      .stat(sqrt_stat), .root(root));

    // step against the last sample, at acceptance
    logic signed [32:0] step;
    logic [32:0]        step_mag;
    logic signed [32:0] mean_diff;
    logic [31:0]        total_next, run_next;
    logic accept;

    assign accept     = item.valid && item.ready;
    assign step       = 33'(signed'(item.sample_value)) - 33'(last_sample_reg);
    assign step_mag   = step[32] ? 33'(-step) : step;
    assign mean_diff  = 33'(signed'(item.sample_value)) - 33'(mean_reg);
    assign total_next = (total_reg == '1) ? total_reg : total_reg + 32'd1;
    assign run_next   = (run_reg == '1) ? run_reg : run_reg + 32'd1;

    // mean update and deviation of the sample from the new mean
    logic [32:0]        q_signed;
    logic signed [31:0] mean_new;
    logic signed [32:0] dev_d;
    assign q_signed = neg_reg ? 33'(-div_q[32:0]) : div_q[32:0];
    assign mean_new = mean_reg + q_signed[31:0];
    assign dev_d    = 33'(last_sample_reg) - 33'(mean_new);

    // classification of the current state
    logic        stable_now;
    logic [2:0]  class_new;
    logic signed [33:0] lstep_w, lim_w;
    assign lstep_w    = 34'(last_step_reg);
    assign lim_w      = {2'b00, trend_limit_reg};
    assign stable_now = (run_reg != '0) && (run_start_reg != '0) &&
                        ((now_reg - run_start_reg) >= stable_hold_ms_reg);
    always_comb
    begin
        priority if (stable_now)
            class_new = stc_pkg::BEH_STABLE;
        else if (total_reg < 32'd3)
            class_new = stc_pkg::BEH_UNKNOWN;
        else if (deviation_reg >= fluctuation_limit_reg)
            class_new = stc_pkg::BEH_FLUCTUATING;
        else if (lstep_w > lim_w)
            class_new = stc_pkg::BEH_INCREASING;
        else if (lstep_w < -lim_w)
            class_new = stc_pkg::BEH_DECREASING;
        else
            class_new = stc_pkg::BEH_INTERMITTENT;
    end

    assign item.ready = (state_reg == S_IDLE);

    // sequencer and statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= S_IDLE;
            stable_step_limit_reg <= stc_pkg::StableStepReset;
            trend_limit_reg       <= stc_pkg::TrendReset;
            fluctuation_limit_reg <= stc_pkg::FluctuationReset;
            stable_hold_ms_reg    <= stc_pkg::HoldMsReset;
            last_sample_reg       <= '0;
            mean_reg              <= '0;
            last_step_reg         <= '0;
            variance_reg          <= '0;
            deviation_reg         <= '0;
            total_reg             <= '0;
            run_reg               <= '0;
            run_start_reg         <= '0;
            now_reg               <= '0;
            settled_reg           <= 1'b0;
            class_reg             <= stc_pkg::BEH_UNKNOWN;
            neg_reg               <= 1'b0;
            var_add_reg           <= 1'b0;
            div_ctrl_reg          <= '0;
            mul_ctrl_reg          <= '0;
            sqrt_ctrl_reg         <= '0;
            div_a_reg             <= '0;
            mul_a_reg             <= '0;
            out_valid_reg         <= 1'b0;
            o_beh_reg             <= '0;
            o_mean_reg            <= '0;
            o_var_reg             <= '0;
            o_dev_reg             <= '0;
            o_trend_reg           <= '0;
            o_latest_reg          <= '0;
            o_seen_reg            <= '0;
            o_settled_reg         <= 1'b0;
        end
        else
        begin
            div_ctrl_reg  <= '0;
            mul_ctrl_reg  <= '0;
            sqrt_ctrl_reg <= '0;
            if (out_valid_reg && result.ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    stc_pkg::REG_STABLE_STEP: stable_step_limit_reg <= cfg_data;
                    stc_pkg::REG_TREND:       trend_limit_reg       <= cfg_data;
                    stc_pkg::REG_FLUCTUATION: fluctuation_limit_reg <= cfg_data;
                    stc_pkg::REG_HOLD_MS:     stable_hold_ms_reg    <= cfg_data;
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        now_reg <= item.now_ms;
                        if (item.op != stc_pkg::OP_SAMPLE)
                        begin
                            state_reg <= S_DONE;
                        end
                        else if (total_reg == '0)
                        begin
                            // first sample seeds the state only
                            last_sample_reg  <= item.sample_value;
                            mean_reg         <= item.sample_value;
                            total_reg        <= 32'd1;
                            run_start_reg    <= item.now_ms;
                            state_reg        <= S_DONE;
                        end
                        else
                        begin
                            last_sample_reg  <= item.sample_value;
                            total_reg        <= total_next;
                            if (step > 33'sh0_7FFF_FFFF)
                                last_step_reg <= 32'sh7FFF_FFFF;
                            else if (step < -33'sh0_8000_0000)
                                last_step_reg <= 32'sh8000_0000;
                            else
                                last_step_reg <= step[31:0];
                            if (step_mag <= {1'b0, stable_step_limit_reg})
                            begin
                                run_reg <= run_next;
                                if (run_next == 32'd1)
                                    run_start_reg <= item.now_ms;
                            end
                            else
                            begin
                                run_reg       <= '0;
                                run_start_reg <= '0;
                                settled_reg   <= 1'b0;
                            end
                            neg_reg      <= mean_diff[32];
                            div_a_reg    <= 65'(mean_diff[32] ? 33'(-mean_diff) : mean_diff);
                            div_ctrl_reg <= '{start: 1'b1};
                            state_reg    <= S_DIV_MEAN;
                        end
                    end
                end
                S_DIV_MEAN:
                begin
                    if (div_stat.done)
                    begin
                        mean_reg     <= mean_new;
                        mul_a_reg    <= dev_d[32] ? 33'(-dev_d) : dev_d;
                        mul_ctrl_reg <= '{start: 1'b1};
                        state_reg    <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (mul_stat.done)
                    begin
                        if (product >= variance_reg)
                        begin
                            var_add_reg <= 1'b1;
                            div_a_reg   <= 65'(product - variance_reg);
                        end
                        else
                        begin
                            var_add_reg <= 1'b0;
                            div_a_reg   <= 65'(variance_reg - product) + 65'(total_reg)
                                           - 65'd1;
                        end
                        div_ctrl_reg <= '{start: 1'b1};
                        state_reg    <= S_DIV_VAR;
                    end
                end
                S_DIV_VAR:
                begin
                    if (div_stat.done)
                    begin
                        variance_reg  <= var_add_reg ? variance_reg + div_q[63:0]
                                                     : variance_reg - div_q[63:0];
                        sqrt_ctrl_reg <= '{start: 1'b1};
                        state_reg     <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (sqrt_stat.done)
                    begin
                        deviation_reg <= root;
                        state_reg     <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // classify unless nothing has been sampled or this was the seed
                    if (!out_valid_reg || result.ready)
                    begin
                        if (!seed_item_reg)
                        begin
                            class_reg     <= class_new;
                            settled_reg   <= settled_reg | stable_now;
                            o_beh_reg     <= class_new;
                            o_settled_reg <= settled_reg | stable_now;
                        end
                        else
                        begin
                            o_beh_reg     <= class_reg;
                            o_settled_reg <= settled_reg;
                        end
                        o_mean_reg    <= mean_reg;
                        o_var_reg     <= variance_reg;
                        o_dev_reg     <= deviation_reg;
                        o_trend_reg   <= last_step_reg;
                        o_latest_reg  <= last_sample_reg;
                        o_seen_reg    <= total_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // seed marker, taken at transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_item_reg <= 1'b0;
        else if (accept)
            seed_item_reg <= (total_reg == '0);
    end

    assign result.valid        = out_valid_reg;
    assign result.behavior     = o_beh_reg;
    assign result.mean_out     = o_mean_reg;
    assign result.variance_out = o_var_reg;
    assign result.std_dev_out  = o_dev_reg;
    assign result.trend_out    = o_trend_reg;
    assign result.latest_value = o_latest_reg;
    assign result.samples_seen = o_seen_reg;
    assign result.is_settled   = o_settled_reg;
endmodule

### hdl/stc_divu.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on stc_pkg.
module stc_divu (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  stc_pkg::unit_ctrl_t                  ctrl,
    input  logic [stc_pkg::DividendWidth-1:0]    dividend,
    input  logic [31:0]                          divisor,
    output stc_pkg::unit_stat_t                  stat,
    output logic [stc_pkg::DividendWidth-1:0]    quotient
);
    logic [stc_pkg::DividendWidth-1:0] quo_reg;
    logic [32:0]                       rem_reg;
    logic [31:0]                       div_reg;
    logic [6:0]                        cnt_reg;
    logic                              busy_reg;
    logic                              done_reg;
    logic [33:0]                       trial;

    // partial remainder with the next dividend bit brought in
    assign trial = {rem_reg, quo_reg[stc_pkg::DividendWidth-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                div_reg  <= divisor;
                cnt_reg  <= 7'(stc_pkg::DividendWidth);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (trial >= {2'b00, div_reg})
                begin
                    rem_reg <= 33'(trial - {2'b00, div_reg});
                    quo_reg <= {quo_reg[stc_pkg::DividendWidth-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[32:0];
                    quo_reg <= {quo_reg[stc_pkg::DividendWidth-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
endmodule

### hdl/stc_mulu.sv
// Shift-and-add multiplier, one multiplier bit per cycle, low 64 product bits.
// Depends on stc_pkg.
module stc_mulu (
    input  logic                             clk,
    input  logic                             rst_n,
    input  stc_pkg::unit_ctrl_t              ctrl,
    input  logic [stc_pkg::MulWidth-1:0]     a,
    input  logic [stc_pkg::MulWidth-1:0]     b,
    output stc_pkg::unit_stat_t              stat,
    output logic [63:0]                      product
);
    logic [63:0]                   acc_reg;
    logic [63:0]                   mcand_reg;
    logic [stc_pkg::MulWidth-1:0]  mplier_reg;
    logic [5:0]                    cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            cnt_reg    <= '0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                acc_reg    <= '0;
                mcand_reg  <= 64'(a);
                mplier_reg <= b;
                cnt_reg    <= 6'(stc_pkg::MulWidth);
                busy_reg   <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (mplier_reg[0])
                    acc_reg <= acc_reg + mcand_reg;
                mcand_reg  <= {mcand_reg[62:0], 1'b0};
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = acc_reg;
endmodule

### hdl/stc_isqrt.sv
// Digit-serial integer square root, two radicand bits per cycle.
// Depends on stc_pkg.
module stc_isqrt (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stc_pkg::unit_ctrl_t  ctrl,
    input  logic [63:0]          radicand,
    output stc_pkg::unit_stat_t  stat,
    output logic [31:0]          root
);
    logic [63:0] val_reg;
    logic [35:0] rem_reg;
    logic [31:0] root_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [35:0] shifted;
    logic [35:0] trial;

    assign shifted = {rem_reg[33:0], val_reg[63:62]};
    assign trial   = {2'b00, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                val_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= 6'd32;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                val_reg <= {val_reg[61:0], 2'b00};
                if (shifted >= trial)
                begin
                    rem_reg  <= shifted - trial;
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= shifted;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;
endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for signal_trend_classifier_core: a directed table, then random phases.
// An in-bench predictor tracks the block's statistics; depends on stc_pkg and stc_if.
module tb_top;

    typedef struct {
        stc_pkg::behavior_t beh;
        logic [31:0] mean;
        logic [63:0] variance;
        logic [31:0] std_dev;
        logic [31:0] trend;
        logic [31:0] latest;
        logic [31:0] count;
        logic        settled;
    } stats_t;

    typedef struct {
        logic        op;
        logic [31:0] value;
        logic [31:0] now;
        logic        pinned;
        stc_pkg::behavior_t beh;
        logic [31:0] count;
    } dir_row_t;

    localparam logic OP_REEVAL = 1'b1;
    localparam logic [stc_pkg::CfgIndexWidth-1:0] UNUSED_INDEX = 4'd9;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 140;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [stc_pkg::CfgIndexWidth-1:0] cfg_index;
    logic [31:0] cfg_data;

    stc_item_if   item_ch ();
    stc_result_if result_ch ();

    signal_trend_classifier_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    // predictor registers and statistics
    logic [31:0] lim_stable, lim_trend, lim_fluct, lim_hold;
    int          p_last, p_prior, p_mean, p_step;
    logic [63:0] p_var;
    logic [31:0] p_sd, p_count, p_run, p_start;
    logic        p_settled;
    stc_pkg::behavior_t p_class;

    stats_t      expected_stats_q[$];
    int          mismatches;
    int          results_seen;
    logic        steady;

    dir_row_t dir_rows[19] = '{
        '{OP_REEVAL, 32'hFFFF_FFFF, 32'd5, 1'b1, stc_pkg::BEH_UNKNOWN, 32'd0},
        '{stc_pkg::OP_SAMPLE, 32'h7FFF_FFFF, 32'd0, 1'b1, stc_pkg::BEH_UNKNOWN, 32'd1},
        '{stc_pkg::OP_SAMPLE, 32'h8000_0000, 32'd100, 1'b1, stc_pkg::BEH_UNKNOWN, 32'd2},
        '{stc_pkg::OP_SAMPLE, 32'h7FFF_FFFF, 32'd200, 1'b0, stc_pkg::BEH_UNKNOWN, 32'd0},
        '{stc_pkg::OP_SAMPLE, 32'h0001_0000, 32'd300, 1'b0, stc_pkg::BEH_UNKNOWN, 32'd0},
        '{stc_pkg::OP_SAMPLE, 32'h0001_0000, 32'd1000, 1'b0, stc_pkg::BEH_UNKNOWN, 32'd0},
        '{stc_pkg::OP_SAMPLE, 32'h0001_0400, 32'd5000, 1'b0, stc_pkg::BEH_UNKNOWN, 32'd0},
        '{stc_pkg::OP_SAMPLE, 32'h0001_0400, 32'd11000, 1'b1, stc_pkg::BEH_STABLE, 32'd7},
        '{OP_REEVAL, 32'h5555_AAAA, 32'hFFFF_FFFF, 1'b1, stc_pkg::BEH_STABLE, 32'd7},
        '{stc_pkg::OP_SAMPLE, 32'h0000_0000, 32'd40000, 1'b0, stc_pkg::BEH_UNKNOWN, 32'd0},
        // run beginning at time zero stays unset
        '{stc_pkg::OP_SAMPLE, 32'h0000_0000, 32'd0, 1'b0, stc_pkg::BEH_UNKNOWN, 32'd0},
        '{stc_pkg::OP_SAMPLE, 32'h0000_0000, 32'd50000, 1'b0, stc_pkg::BEH_UNKNOWN, 32'd0},
        '{OP_REEVAL, 32'h0000_0000, 32'd90000, 1'b0, stc_pkg::BEH_UNKNOWN, 32'd0},
        '{stc_pkg::OP_SAMPLE, 32'h0003_0000, 32'd91000, 1'b0, stc_pkg::BEH_UNKNOWN, 32'd0},
        '{stc_pkg::OP_SAMPLE, 32'h0006_0000, 32'd92000, 1'b0, stc_pkg::BEH_UNKNOWN, 32'd0},
        '{stc_pkg::OP_SAMPLE, 32'h0002_0000, 32'd93000, 1'b0, stc_pkg::BEH_UNKNOWN, 32'd0},
        '{stc_pkg::OP_SAMPLE, 32'hFFFF_0000, 32'd94000, 1'b0, stc_pkg::BEH_UNKNOWN, 32'd0},
        '{stc_pkg::OP_SAMPLE, 32'h8000_0001, 32'd95000, 1'b0, stc_pkg::BEH_UNKNOWN, 32'd0},
        '{stc_pkg::OP_SAMPLE, 32'h7FFF_FFFE, 32'd96000, 1'b0, stc_pkg::BEH_UNKNOWN, 32'd0}
    };

    // clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // floor square root, two bits per pass
    function automatic logic [31:0] floor_root(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 64'd0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res[31:0];
    endfunction

    function automatic void classify_at(logic [31:0] now);
        logic [31:0] elapsed;
        longint      lim;
        elapsed = now - p_start;
        lim = longint'(lim_trend);
        if (p_run != 0 && p_start != 0 && elapsed >= lim_hold)
        begin
            p_settled = 1'b1;
            p_class = stc_pkg::BEH_STABLE;
        end
        else if (p_count < 3)
            p_class = stc_pkg::BEH_UNKNOWN;
        else if (p_sd >= lim_fluct)
            p_class = stc_pkg::BEH_FLUCTUATING;
        else if (longint'(p_step) > lim)
            p_class = stc_pkg::BEH_INCREASING;
        else if (longint'(p_step) < -lim)
            p_class = stc_pkg::BEH_DECREASING;
        else
            p_class = stc_pkg::BEH_INTERMITTENT;
    endfunction

    function automatic void absorb_sample(int v, logic [31:0] now);
        longint      step, diff, dev, mag;
        logic [63:0] n64, d2, dm;
        if (p_count == 0)
        begin
            p_last = v;
            p_prior = v;
            p_mean = v;
            p_count = 32'd1;
            p_start = now;
            return;
        end
        p_prior = p_last;
        p_last = v;
        if (p_count != 32'hFFFF_FFFF)
            p_count = p_count + 1;
        n64 = {32'd0, p_count};

        step = longint'(v) - longint'(p_prior);
        if (step > longint'(32'sh7FFF_FFFF))
            p_step = 32'sh7FFF_FFFF;
        else if (step < -longint'(32'h8000_0000))
            p_step = 32'sh8000_0000;
        else
            p_step = int'(step);

        diff = longint'(v) - longint'(p_mean);
        p_mean = int'(longint'(p_mean) + diff / longint'(n64));

        mag = (step < 0) ? -step : step;
        if (mag <= longint'(lim_stable))
        begin
            if (p_run != 32'hFFFF_FFFF)
                p_run = p_run + 1;
            if (p_run == 32'd1)
                p_start = now;
        end
        else
        begin
            p_run = 32'd0;
            p_start = 32'd0;
            p_settled = 1'b0;
        end

        dev = longint'(v) - longint'(p_mean);
        dm = (dev < 0) ? 64'(-dev) : 64'(dev);
        d2 = dm * dm;
        if (d2 >= p_var)
            p_var = p_var + (d2 - p_var) / n64;
        else
            p_var = p_var - (p_var - d2 + n64 - 64'd1) / n64;
        p_sd = floor_root(p_var);
        classify_at(now);
    endfunction

    function automatic stats_t predict_stats(logic op, logic [31:0] value, logic [31:0] now);
        stats_t s;
        if (op == stc_pkg::OP_SAMPLE)
            absorb_sample(int'(value), now);
        else if (p_count != 0)
            classify_at(now);
        s.beh = p_class;
        s.mean = p_mean;
        s.variance = p_var;
        s.std_dev = p_sd;
        s.trend = p_step;
        s.latest = p_last;
        s.count = p_count;
        s.settled = p_settled;
        return s;
    endfunction

    task automatic write_reg(logic [stc_pkg::CfgIndexWidth-1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        case (idx)
            stc_pkg::REG_STABLE_STEP: lim_stable = data;
            stc_pkg::REG_TREND:       lim_trend = data;
            stc_pkg::REG_FLUCTUATION: lim_fluct = data;
            stc_pkg::REG_HOLD_MS:     lim_hold = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic drain_results();
        while (expected_stats_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // offer one item and record its expected statistics once transferred
    task automatic send_item(logic op, logic [31:0] value, logic [31:0] now,
                             logic pinned, stc_pkg::behavior_t beh, logic [31:0] count);
        int     gap;
        stats_t s;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid = 1'b1;
        item_ch.op = op;
        item_ch.sample_value = value;
        item_ch.now_ms = now;
        do
            @(posedge clk);
        while (!item_ch.ready);
        s = predict_stats(op, value, now);
        if (pinned)
        begin
            s.beh = beh;
            s.count = count;
        end
        expected_stats_q.push_back(s);
        @(negedge clk);
        item_ch.valid = 1'b0;
    endtask

    task automatic note_field(string name, logic [63:0] exp_v, logic [63:0] act_v,
                              inout logic bad);
        if (exp_v !== act_v)
        begin
            bad = 1'b1;
            if (mismatches < 10)
                $display("result %0d: %s expected %0h got %0h", results_seen, name, exp_v,
                         act_v);
        end
    endtask

    // result side: random stalls, one long hold-off
    initial
    begin
        int     stall;
        logic   held;
        logic   bad;
        stats_t e;
        held = 1'b0;
        result_ch.ready = 1'b0;
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 8);
            if (!held && results_seen == 200)
            begin
                stall = HOLD_OFF_CYCLES;
                held = 1'b1;
            end
            @(negedge clk);
            if (stall > 0)
            begin
                result_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            if (expected_stats_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("result %0d arrived with nothing expected", results_seen);
                mismatches++;
            end
            else
            begin
                e = expected_stats_q.pop_front();
                bad = 1'b0;
                note_field("behavior", e.beh, result_ch.behavior, bad);
                note_field("mean_out", e.mean, result_ch.mean_out, bad);
                note_field("variance_out", e.variance, result_ch.variance_out, bad);
                note_field("std_dev_out", e.std_dev, result_ch.std_dev_out, bad);
                note_field("trend_out", e.trend, result_ch.trend_out, bad);
                note_field("latest_value", e.latest, result_ch.latest_value, bad);
                note_field("samples_seen", e.count, result_ch.samples_seen, bad);
                note_field("is_settled", e.settled, result_ch.is_settled, bad);
                if (bad)
                    mismatches++;
            end
            results_seen++;
        end
    end

    // watchdog
    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus
    initial
    begin
        int          level;
        int          delta;
        logic [31:0] clock_ms;
        logic [31:0] value;
        logic        op;
        mismatches = 0;
        results_seen = 0;
        steady = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.op = stc_pkg::OP_SAMPLE;
        item_ch.sample_value = '0;
        item_ch.now_ms = '0;
        lim_stable = stc_pkg::StableStepReset;
        lim_trend = stc_pkg::TrendReset;
        lim_fluct = stc_pkg::FluctuationReset;
        lim_hold = stc_pkg::HoldMsReset;
        p_last = 0;
        p_prior = 0;
        p_mean = 0;
        p_step = 0;
        p_var = '0;
        p_sd = '0;
        p_count = '0;
        p_run = '0;
        p_start = '0;
        p_settled = 1'b0;
        p_class = stc_pkg::BEH_UNKNOWN;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table, reset register values
        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].value, dir_rows[i].now,
                      dir_rows[i].pinned, dir_rows[i].beh, dir_rows[i].count);

        // random phases, each under its own register setting
        level = 0;
        clock_ms = 32'd100000;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            case (ph)
                0:
                begin
                    write_reg(stc_pkg::REG_STABLE_STEP, stc_pkg::StableStepReset);
                    write_reg(stc_pkg::REG_TREND, stc_pkg::TrendReset);
                    write_reg(stc_pkg::REG_FLUCTUATION, stc_pkg::FluctuationReset);
                    write_reg(stc_pkg::REG_HOLD_MS, stc_pkg::HoldMsReset);
                end
                1:
                begin
                    write_reg(stc_pkg::REG_STABLE_STEP, 32'd0);
                    write_reg(stc_pkg::REG_TREND, 32'd0);
                    write_reg(stc_pkg::REG_FLUCTUATION, 32'd0);
                    write_reg(stc_pkg::REG_HOLD_MS, 32'd0);
                    write_reg(UNUSED_INDEX, 32'hDEAD_BEEF);
                end
                2:
                begin
                    write_reg(stc_pkg::REG_STABLE_STEP, 32'hFFFF_FFFF);
                    write_reg(stc_pkg::REG_TREND, 32'hFFFF_FFFF);
                    write_reg(stc_pkg::REG_FLUCTUATION, 32'hFFFF_FFFF);
                    write_reg(stc_pkg::REG_HOLD_MS, 32'hFFFF_FFFF);
                end
                3:
                begin
                    write_reg(stc_pkg::REG_STABLE_STEP, 32'd5000);
                    write_reg(stc_pkg::REG_TREND, 32'h0000_4000);
                    write_reg(stc_pkg::REG_FLUCTUATION, 32'h0020_0000);
                    write_reg(stc_pkg::REG_HOLD_MS, 32'd3000);
                end
                4:
                begin
                    write_reg(stc_pkg::REG_STABLE_STEP, $urandom);
                    write_reg(stc_pkg::REG_TREND, $urandom);
                    write_reg(stc_pkg::REG_FLUCTUATION, $urandom);
                    write_reg(stc_pkg::REG_HOLD_MS, $urandom);
                end
                default:
                begin
                    write_reg(stc_pkg::REG_STABLE_STEP, 32'd20000);
                    write_reg(stc_pkg::REG_TREND, 32'h0000_1000);
                    write_reg(stc_pkg::REG_FLUCTUATION, 32'hFFFF_FFFF);
                    write_reg(stc_pkg::REG_HOLD_MS, 32'd0);
                end
            endcase

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(0, 40) == 0)
                    steady = ~steady;
                op = ($urandom_range(0, 99) < 15) ? OP_REEVAL : stc_pkg::OP_SAMPLE;
                // mostly small steps so stable runs form, some trends, rare wild values
                case ($urandom_range(0, 19))
                    0: delta = $urandom;
                    1, 2, 3: delta = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
                    default: delta = $signed($urandom_range(0, 8000)) - 4000;
                endcase
                level = level + delta;
                value = (op == OP_REEVAL) ? $urandom : level;
                if ($urandom_range(0, 49) == 0)
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms + $urandom_range(0, 6000);
                send_item(op, value, clock_ms, 1'b0, stc_pkg::BEH_UNKNOWN, 32'd0);
            end
        end

        @(negedge clk);
        item_ch.valid = 1'b0;
        while (expected_stats_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (mismatches == 0 && expected_stats_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
